>>> hw/rtl/cfpd_pkg.sv
// ============================================================================
// cfpd_pkg
// Types and constants shared by the framed packet deframer.
// ============================================================================
package cfpd_pkg;

    // Frame constants
    localparam logic [7:0]  MAGIC_FIRST  = 8'hAB;
    localparam logic [7:0]  MAGIC_SECOND = 8'hCD;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // Configuration port
    localparam int unsigned PADDR_W          = 3;
    localparam int unsigned PDATA_W          = 32;
    localparam logic [0:0]  REG_MAX_PAYLOAD  = 1'b0;
    localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1024;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_MAGIC_L = 7'b0000001,
        PH_MAGIC_H = 7'b0000010,
        PH_LEN_L   = 7'b0000100,
        PH_LEN_H   = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CRC_L   = 7'b0100000,
        PH_CRC_H   = 7'b1000000
    } phase_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [15:0] max_payload;
    } cfg_t;

    // Reflected CRC-16 update over one byte, eight narrow shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/cfpd_byte_if.sv
// ============================================================================
// cfpd_byte_if
// Valid/ready channel carrying one received byte per transfer.
// ============================================================================
interface cfpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/cfpd_result_if.sv
// ============================================================================
// cfpd_result_if
// Valid/ready channel carrying one deframer result per transfer.
// ============================================================================
interface cfpd_result_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    logic        frame_good;
    logic [15:0] frame_length;
    logic        length_error;

    modport source (
        output valid, input ready,
        output payload_valid, output payload_byte, output payload_index,
        output frame_done, output frame_good, output frame_length, output length_error
    );
    modport sink (
        input valid, output ready,
        input payload_valid, input payload_byte, input payload_index,
        input frame_done, input frame_good, input frame_length, input length_error
    );
endinterface

>>> hw/rtl/cfpd_apb_regs.sv
// ============================================================================
// cfpd_apb_regs
// APB register file: holds the maximum payload length.
// ============================================================================
module cfpd_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfpd_pkg::PADDR_W-1:0] paddr,
    input  logic [cfpd_pkg::PDATA_W-1:0] pwdata,
    output logic [cfpd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output cfpd_pkg::cfg_t              cfg
);
    import cfpd_pkg::*;

    logic [15:0] max_payload_reg;
    logic        wr_en;
    logic [0:0]  reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2:2];
    assign wr_en     = psel && penable && pwrite && pready;

    // Register write; writes beyond the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (wr_en && (reg_index == REG_MAX_PAYLOAD))
        begin
            max_payload_reg <= pwdata[15:0];
        end
    end

    // Readback
    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_MAX_PAYLOAD)
            prdata = {{(PDATA_W-16){1'b0}}, max_payload_reg};
    end

    assign cfg.max_payload = max_payload_reg;

endmodule

>>> hw/rtl/cfpd_parser.sv
// ============================================================================
// cfpd_parser
// Input byte register, frame parse logic with CRC update, result register.
// ============================================================================
module cfpd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  cfpd_pkg::cfg_t cfg,
    cfpd_byte_if.sink      rx,
    cfpd_result_if.source  result
);
    import cfpd_pkg::*;

    // Input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    // Parse state
    phase_t      phase_reg, phase_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    // Result stage
    logic        out_valid_reg;
    logic        pv_next, done_next, good_next, lerr_next;
    logic [7:0]  pbyte_next;
    logic [15:0] pindex_next, flen_next;
    logic        pv_reg, done_reg, good_reg, lerr_reg;
    logic [7:0]  pbyte_reg;
    logic [15:0] pindex_reg, flen_reg;

    // Combinational helpers
    logic [15:0] len_full;
    logic [15:0] count_inc;

    // Move the held byte into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready = !in_valid_reg || advance;

    // Input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
    end

    // Parse logic for the held byte
    assign len_full  = {in_byte_reg, decl_len_reg[7:0]};
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        decl_len_next = decl_len_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_low_next  = crc_low_reg;
        pv_next       = 1'b0;
        pbyte_next    = '0;
        pindex_next   = '0;
        done_next     = 1'b0;
        good_next     = 1'b0;
        flen_next     = '0;
        lerr_next     = 1'b0;
        unique case (phase_reg)
            PH_MAGIC_L:
            begin
                if (in_byte_reg == MAGIC_FIRST)
                    phase_next = PH_MAGIC_H;
            end
            PH_MAGIC_H:
            begin
                if (in_byte_reg == MAGIC_SECOND)
                    phase_next = PH_LEN_L;
                else if (in_byte_reg != MAGIC_FIRST)
                    phase_next = PH_MAGIC_L;
            end
            PH_LEN_L:
            begin
                decl_len_next = {8'h00, in_byte_reg};
                phase_next    = PH_LEN_H;
            end
            PH_LEN_H:
            begin
                decl_len_next = len_full;
                count_next    = '0;
                crc_next      = '0;
                if ((len_full == 16'd0) || (len_full > cfg.max_payload))
                begin
                    lerr_next    = 1'b1;
                    crc_low_next = '0;
                    phase_next   = PH_MAGIC_L;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                pv_next     = 1'b1;
                pbyte_next  = in_byte_reg;
                pindex_next = count_reg;
                crc_next    = crc_byte(crc_reg, in_byte_reg);
                count_next  = count_inc;
                if (count_inc >= decl_len_reg)
                    phase_next = PH_CRC_L;
            end
            PH_CRC_L:
            begin
                crc_low_next = in_byte_reg;
                phase_next   = PH_CRC_H;
            end
            PH_CRC_H:
            begin
                done_next    = 1'b1;
                good_next    = ({in_byte_reg, crc_low_reg} == crc_reg);
                flen_next    = decl_len_reg;
                phase_next   = PH_MAGIC_L;
                count_next   = '0;
                crc_next     = '0;
                crc_low_next = '0;
            end
            default:
            begin
                phase_next   = PH_MAGIC_L;
                count_next   = '0;
                crc_next     = '0;
                crc_low_next = '0;
            end
        endcase
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC_L;
            decl_len_reg <= '0;
            count_reg    <= '0;
            crc_reg      <= '0;
            crc_low_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            decl_len_reg <= decl_len_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_low_reg  <= crc_low_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pv_reg     <= pv_next;
            pbyte_reg  <= pbyte_next;
            pindex_reg <= pindex_next;
            done_reg   <= done_next;
            good_reg   <= good_next;
            flen_reg   <= flen_next;
            lerr_reg   <= lerr_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.payload_valid = pv_reg;
    assign result.payload_byte  = pbyte_reg;
    assign result.payload_index = pindex_reg;
    assign result.frame_done    = done_reg;
    assign result.frame_good    = good_reg;
    assign result.frame_length  = flen_reg;
    assign result.length_error  = lerr_reg;

    // Checks
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones({pv_reg, done_reg, lerr_reg}) <= 1))
        else $error("result carries more than one event");

    a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && good_reg) |-> done_reg)
        else $error("frame_good without frame_done");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (count_reg < decl_len_reg))
        else $error("payload count reached declared length in payload phase");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced byte left no result");

endmodule

>>> hw/rtl/crc16_framed_packet_deframer_unit.sv
// ============================================================================
// crc16_framed_packet_deframer_unit
// Deframer for 0xAB 0xCD | length LE16 | payload | CRC-16 LE16 frames.
// ============================================================================
//
//  channel   dir   handshake        contents
//  -------   ---   --------------   -----------------------------------------
//  rx        in    valid / ready    rx_byte, one received byte per transfer
//  result    out   valid / ready    payload, frame-done and length-error info
//  apb       in    psel / penable   max_payload at byte address 0
//
//  Each accepted byte yields one result, held first in the input byte
//  register and then in the result register.
//  One byte per cycle sustained while result.ready stays high; the CRC update is an unrolled 8-bit step.
//  A stalled result holds its register; the input register keeps taking bytes
//  until it too is full, then rx.ready drops.
//  Reset (rst_n low, asynchronous) returns to magic hunting, max_payload 1024.
//
module crc16_framed_packet_deframer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfpd_pkg::PADDR_W-1:0] paddr,
    input  logic [cfpd_pkg::PDATA_W-1:0] pwdata,
    output logic [cfpd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    cfpd_byte_if.sink                   rx,
    cfpd_result_if.source               result
);
    import cfpd_pkg::*;

    cfg_t cfg;

    cfpd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfpd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .rx     (rx),
        .result (result)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the CRC-16 framed packet deframer.
// Byte streams go in on the rx channel: hand-built corner cases, maximum-length
// checks, then mixed random traffic under four idle and stall profiles. A
// behavioral deframer predicts every result transfer, and the checker compares
// it field by field. max_payload is written and read back over APB between
// phases, once the block has gone quiet.
// ============================================================================
module tb;
    import cfpd_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done;
        logic        frame_good;
        logic [15:0] frame_length;
        logic        length_error;
    } deframe_result_t;

    localparam logic [PADDR_W-1:0] ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_TAIL  = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cfpd_byte_if   rx_ch ();
    cfpd_result_if res_ch ();

    crc16_framed_packet_deframer_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (rx_ch),
        .result  (res_ch)
    );

    // Deframer state as the bench sees it
    phase_t      parse_ph        = PH_MAGIC_L;
    logic [15:0] max_payload_cfg = MAX_PAYLOAD_RST;
    logic [15:0] decl_len        = '0;
    logic [15:0] byte_cnt        = '0;
    logic [15:0] run_crc         = '0;
    logic [7:0]  crc_lo          = '0;

    deframe_result_t pending_results[$];
    deframe_result_t oldest;
    int unsigned     mismatch_count = 0;
    int unsigned     sent_count     = 0;
    int              idle_cycles    = 0;
    int              send_idle_pct  = 0;
    int              stall_pct      = 0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Reflected CRC-16, one data bit at a time, LSB first
    function automatic logic [15:0] crc16_arc_next(input logic [15:0] crc,
                                                   input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void restart_hunt();
        parse_ph = PH_MAGIC_L;
        byte_cnt = '0;
        run_crc  = '0;
        crc_lo   = '0;
    endfunction

    // Result of deframing one accepted byte; advances the bench's state
    function automatic deframe_result_t deframe_byte(input logic [7:0] b);
        deframe_result_t r;
        logic [15:0]     rx_crc;
        r = '0;
        case (parse_ph)
            PH_MAGIC_L:
            begin
                if (b == MAGIC_FIRST)
                    parse_ph = PH_MAGIC_H;
            end
            PH_MAGIC_H:
            begin
                if (b == MAGIC_SECOND)
                    parse_ph = PH_LEN_L;
                else if (b != MAGIC_FIRST)
                    parse_ph = PH_MAGIC_L;
            end
            PH_LEN_L:
            begin
                decl_len = {8'h00, b};
                parse_ph = PH_LEN_H;
            end
            PH_LEN_H:
            begin
                decl_len[15:8] = b;
                byte_cnt = '0;
                run_crc  = '0;
                if (decl_len == 16'd0 || decl_len > max_payload_cfg)
                begin
                    r.length_error = 1'b1;
                    restart_hunt();
                end
                else
                begin
                    parse_ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = byte_cnt;
                run_crc  = crc16_arc_next(run_crc, b);
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt >= decl_len)
                    parse_ph = PH_CRC_L;
            end
            PH_CRC_L:
            begin
                crc_lo   = b;
                parse_ph = PH_CRC_H;
            end
            PH_CRC_H:
            begin
                rx_crc = {b, crc_lo};
                r.frame_done   = 1'b1;
                r.frame_good   = (rx_crc == run_crc);
                r.frame_length = decl_len;
                restart_hunt();
            end
            default:
            begin
                restart_hunt();
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    function automatic byte_q_t random_payload(input int n);
        byte_q_t q;
        repeat (n) q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    // Mostly short frames; now and then exactly the limit when it is small
    function automatic logic [15:0] pick_length();
        int cap;
        cap = (max_payload_cfg < 16'd24) ? int'(max_payload_cfg) : 24;
        if (cap == 0)
            return 16'($urandom_range(1, 8));
        if (max_payload_cfg <= 16'd64 && $urandom_range(7) == 0)
            return max_payload_cfg;
        return 16'($urandom_range(1, cap));
    endfunction

    // Zero, one past the limit, or anything above it
    function automatic logic [15:0] pick_bad_length();
        if (max_payload_cfg == 16'hFFFF || $urandom_range(2) == 0)
            return 16'h0000;
        if ($urandom_range(1) == 0)
            return max_payload_cfg + 16'd1;
        return 16'($urandom_range(int'(max_payload_cfg) + 1, 65535));
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result: unexpected transfer");
                mismatch_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("payload_valid", 16'(oldest.payload_valid),
                            16'(res_ch.payload_valid));
                check_field("payload_byte", 16'(oldest.payload_byte),
                            16'(res_ch.payload_byte));
                check_field("payload_index", oldest.payload_index, res_ch.payload_index);
                check_field("frame_done", 16'(oldest.frame_done), 16'(res_ch.frame_done));
                check_field("frame_good", 16'(oldest.frame_good), 16'(res_ch.frame_good));
                check_field("frame_length", oldest.frame_length, res_ch.frame_length);
                check_field("length_error", 16'(oldest.length_error),
                            16'(res_ch.length_error));
            end
        end
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL crc16_framed_packet_deframer_unit");
                $finish;
            end
        end
    end

    // One byte transfer, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        sent_count++;
        pending_results.push_back(deframe_byte(b));
    endtask

    // Header, then payload and CRC only when the length will be taken
    task automatic send_frame(input logic [15:0] len, input byte_q_t payload,
                              input bit crc_ok);
        logic [15:0] crc;
        crc = '0;
        send_byte(MAGIC_FIRST);
        send_byte(MAGIC_SECOND);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (len != 16'd0 && len <= max_payload_cfg)
        begin
            foreach (payload[i])
            begin
                crc = crc16_arc_next(crc, payload[i]);
                send_byte(payload[i]);
            end
            if (!crc_ok)
                crc = crc ^ 16'($urandom_range(1, 65535));
            send_byte(crc[7:0]);
            send_byte(crc[15:8]);
        end
    endtask

    // Feed filler until the deframer is back to hunting for magic
    task automatic realign_to_hunt();
        while (parse_ph != PH_MAGIC_L)
        begin
            if (parse_ph inside {PH_MAGIC_H, PH_LEN_L, PH_LEN_H})
                send_byte(8'h00);
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_results_drained(input int tail);
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_max_payload(input logic [15:0] value);
        logic [PDATA_W-1:0] readback;
        wait_results_drained(DRAIN_TAIL);
        apb_write(ADDR_MAX_PAYLOAD, PDATA_W'(value));
        max_payload_cfg = value;
        apb_read(ADDR_MAX_PAYLOAD, readback);
        check_field("max_payload", value, readback[15:0]);
    endtask

    task automatic test_register_reset();
        logic [PDATA_W-1:0] readback;
        apb_read(ADDR_MAX_PAYLOAD, readback);
        check_field("max_payload", MAX_PAYLOAD_RST, readback[15:0]);
    endtask

    task automatic test_framing_corner_cases();
        byte_q_t pl;
        // stray bytes, then a first magic byte not followed by the second
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(MAGIC_FIRST);
        send_byte(8'h00);
        // repeated first magic byte; payload at both byte extremes
        send_byte(MAGIC_FIRST);
        pl = '{8'h00, 8'hFF};
        send_frame(16'd2, pl, 1'b1);
        // CRC mismatch, payload carrying a magic byte
        pl = '{MAGIC_FIRST};
        send_frame(16'd1, pl, 1'b0);
        // zero length, then one past the reset limit
        send_frame(16'd0, pl, 1'b1);
        send_frame(max_payload_cfg + 16'd1, pl, 1'b1);
    endtask

    task automatic test_length_limits();
        set_max_payload(16'd4);
        send_frame(16'd4, random_payload(4), 1'b1);
        send_frame(16'd5, random_payload(5), 1'b1);
        // zero limit rejects every length
        set_max_payload(16'd0);
        send_frame(16'd1, random_payload(1), 1'b1);
        set_max_payload(16'd1);
        send_frame(16'd1, random_payload(1), 1'b1);
        send_frame(16'd2, random_payload(2), 1'b1);
        // largest length one past a near-full limit, zero length at the full limit
        set_max_payload(16'hFFFE);
        send_frame(16'hFFFF, random_payload(0), 1'b1);
        set_max_payload(16'hFFFF);
        send_frame(16'd0, random_payload(0), 1'b1);
    endtask

    task automatic test_random_traffic(input int items, input int idle, input int stall,
                                       input logic [15:0] limit);
        int          start_count;
        int          kind;
        bit          paused;
        logic [15:0] len;
        set_max_payload(limit);
        send_idle_pct = idle;
        stall_pct     = stall;
        start_count   = sent_count;
        paused        = 1'b0;
        while (sent_count - start_count < items)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                len = pick_length();
                send_frame(len, random_payload(len), $urandom_range(3) != 0);
            end
            else if (kind < 78)
            begin
                send_frame(pick_bad_length(), random_payload(0), 1'b1);
            end
            else if (kind < 86)
            begin
                // line noise
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
                realign_to_hunt();
            end
            else if (kind < 94)
            begin
                // frame cut short, next frame swallowed into it
                len = pick_length();
                send_byte(MAGIC_FIRST);
                send_byte(MAGIC_SECOND);
                send_byte(len[7:0]);
                send_byte(len[15:8]);
                repeat ($urandom_range(0, int'(len) - 1)) send_byte(8'($urandom_range(255)));
                len = pick_length();
                send_frame(len, random_payload(len), 1'b1);
                realign_to_hunt();
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_byte(MAGIC_FIRST);
                len = pick_length();
                send_frame(len, random_payload(len), 1'b1);
            end
            // sender holds off once until the result queue is empty
            if (!paused && sent_count - start_count >= items / 2)
            begin
                wait_results_drained(0);
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_framing_corner_cases();
        test_length_limits();
        test_random_traffic(175, 0, 0, 16'd24);
        test_random_traffic(175, 75, 0, 16'd1);
        test_random_traffic(175, 0, 75, 16'hFFFF);
        test_random_traffic(175, 20, 20, 16'($urandom_range(2, 40)));

        wait_results_drained(DRAIN_TAIL);
        if (mismatch_count == 0)
            $display("PASS crc16_framed_packet_deframer_unit");
        else
            $display("FAIL crc16_framed_packet_deframer_unit");
        $finish;
    end

endmodule
